// ----- src/lpr_pkg.sv -----
package lpr_pkg;

  localparam int TDATA_IN_W  = 16;
  localparam int TDATA_OUT_W = 40;
  localparam int FAULT_W     = 16;
  localparam int CFG_W       = 4;
  localparam int IDX_OUT_W   = 3;
  localparam int EVICT_W     = 16;

  localparam logic [FAULT_W-1:0] FAULT_MAX     = '1;
  localparam logic [CFG_W-1:0]   ACTIVE_RESET  = 4'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } lpr_state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } lpr_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_busy;
  } lpr_sts_t;

endpackage

// ----- src/lpr_ctrl.sv -----
module lpr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  lpr_pkg::lpr_sts_t sts,
  output lpr_pkg::lpr_cmd_t cmd
);

  lpr_pkg::lpr_state_t state_r;
  lpr_pkg::lpr_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lpr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lpr_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = lpr_pkg::ST_SCAN;
        end
      end
      lpr_pkg::ST_SCAN: begin
        if (sts.scan_last) begin
          state_nxt = lpr_pkg::ST_UPDATE;
        end
      end
      lpr_pkg::ST_UPDATE: begin
        if (!sts.out_busy) begin
          state_nxt = lpr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lpr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready  = 1'b0;
    cmd        = '0;
    unique case (state_r)
      lpr_pkg::ST_IDLE: begin
        in_tready = rst_n;
        cmd.load  = in_tvalid && rst_n;
      end
      lpr_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
      end
      lpr_pkg::ST_UPDATE: begin
        cmd.commit = !sts.out_busy;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  property p_scan_after_load;
    @(posedge clk) disable iff (!rst_n) cmd.load |=> state_r == lpr_pkg::ST_SCAN;
  endproperty
  a_scan_after_load: assert property (p_scan_after_load)
    else $error("Accepted item did not start a scan.");

  property p_commit_returns_idle;
    @(posedge clk) disable iff (!rst_n) cmd.commit |=> in_tready;
  endproperty
  a_commit_returns_idle: assert property (p_commit_returns_idle)
    else $error("Controller did not return to idle after commit.");

  property p_no_accept_while_busy;
    @(posedge clk) disable iff (!rst_n) (state_r != lpr_pkg::ST_IDLE) |-> !in_tready;
  endproperty
  a_no_accept_while_busy: assert property (p_no_accept_while_busy)
    else $error("Input was ready while an item was in progress.");

endmodule

// ----- src/lpr_dp.sv -----
module lpr_dp #(
  parameter int FRAMES    = 8,
  parameter int PAGE_BITS = 16,
  parameter int AGE_BITS  = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [lpr_pkg::CFG_W-1:0]       cfg_wr_data,
  input  logic [lpr_pkg::TDATA_IN_W-1:0]  in_tdata,
  input  logic                            in_tuser,
  input  logic                            out_tready,
  output logic                            out_tvalid,
  output logic [lpr_pkg::TDATA_OUT_W-1:0] out_tdata,
  input  lpr_pkg::lpr_cmd_t               cmd,
  output lpr_pkg::lpr_sts_t               sts
);

  localparam int IDX_W = $clog2(FRAMES);
  localparam int CNT_W = $clog2(FRAMES + 1);
  localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

  logic [lpr_pkg::CFG_W-1:0]   active_r;
  logic [CNT_W-1:0]            n_used;
  logic [CNT_W-1:0]            n_m1;
  logic [IDX_W-1:0]            last_idx;

  logic [FRAMES-1:0]           valid_r;
  logic [AGE_BITS-1:0]         age_r [FRAMES];
  logic [PAGE_BITS-1:0]        page_mem [FRAMES];
  logic [lpr_pkg::FAULT_W-1:0] fault_r;
  logic [lpr_pkg::FAULT_W-1:0] fault_nxt;

  logic [PAGE_BITS+lpr_pkg::TDATA_IN_W-1:0] page_ext;
  logic [PAGE_BITS-1:0]        page_in;
  logic [PAGE_BITS-1:0]        req_page_r;

  logic [IDX_W-1:0]            idx_r;
  logic                        rd_valid;
  logic [PAGE_BITS-1:0]        rd_page;
  logic [AGE_BITS-1:0]         rd_age;

  logic                        hit_r;
  logic [IDX_W-1:0]            hit_idx_r;
  logic                        empty_r;
  logic [IDX_W-1:0]            empty_idx_r;
  logic [IDX_W-1:0]            best_idx_r;
  logic [AGE_BITS-1:0]         best_age_r;
  logic [PAGE_BITS-1:0]        best_page_r;

  logic [IDX_W-1:0]            slot;
  logic                        evicted;
  logic [IDX_W+lpr_pkg::IDX_OUT_W-1:0]   slot_ext;
  logic [PAGE_BITS+lpr_pkg::EVICT_W-1:0] evict_ext;
  logic [lpr_pkg::EVICT_W-1:0] evict_page;

  logic                        out_valid_r;
  logic [lpr_pkg::TDATA_OUT_W-1:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= lpr_pkg::ACTIVE_RESET;
    end else if (cfg_wr_en) begin
      active_r <= cfg_wr_data;
    end
  end

  always_comb begin
    if (active_r == '0) begin
      n_used = CNT_W'(1);
    end else if (int'(active_r) > FRAMES) begin
      n_used = CNT_W'(FRAMES);
    end else begin
      n_used = CNT_W'(active_r);
    end
  end

  assign n_m1     = n_used - CNT_W'(1);
  assign last_idx = n_m1[IDX_W-1:0];

  assign page_ext = {{PAGE_BITS{1'b0}}, in_tdata};
  assign page_in  = page_ext[PAGE_BITS-1:0];

  assign rd_valid = valid_r[idx_r];
  assign rd_page  = page_mem[idx_r];
  assign rd_age   = age_r[idx_r];

  assign sts.scan_last = (idx_r == last_idx);
  assign sts.out_busy  = out_valid_r && !out_tready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_page_r <= page_in;
      idx_r      <= '0;
    end else if (cmd.scan) begin
      idx_r <= idx_r + IDX_W'(1);
      if (!hit_r && rd_valid && (rd_page == req_page_r)) begin
        hit_idx_r <= idx_r;
      end
      if (!empty_r && !rd_valid) begin
        empty_idx_r <= idx_r;
      end
      if ((idx_r == '0) || (rd_age > best_age_r)) begin
        best_idx_r  <= idx_r;
        best_age_r  <= rd_age;
        best_page_r <= rd_page;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r   <= 1'b0;
      empty_r <= 1'b0;
    end else if (cmd.load) begin
      hit_r   <= 1'b0;
      empty_r <= 1'b0;
    end else if (cmd.scan) begin
      if (rd_valid && (rd_page == req_page_r)) begin
        hit_r <= 1'b1;
      end
      if (!rd_valid) begin
        empty_r <= 1'b1;
      end
    end
  end

  always_comb begin
    priority if (hit_r) begin
      slot = hit_idx_r;
    end else if (empty_r) begin
      slot = empty_idx_r;
    end else begin
      slot = best_idx_r;
    end
  end

  assign evicted    = !hit_r && !empty_r;
  assign slot_ext   = {{lpr_pkg::IDX_OUT_W{1'b0}}, slot};
  assign evict_ext  = {{lpr_pkg::EVICT_W{1'b0}}, (evicted ? best_page_r : '0)};
  assign evict_page = evict_ext[lpr_pkg::EVICT_W-1:0];

  always_comb begin
    if (hit_r || (fault_r == lpr_pkg::FAULT_MAX)) begin
      fault_nxt = fault_r;
    end else begin
      fault_nxt = fault_r + lpr_pkg::FAULT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      fault_r <= '0;
      for (int i = 0; i < FRAMES; i++) begin
        age_r[i] <= '0;
      end
    end else if (cmd.load) begin
      if (in_tuser) begin
        valid_r <= '0;
        fault_r <= '0;
        for (int i = 0; i < FRAMES; i++) begin
          age_r[i] <= '0;
        end
      end
    end else if (cmd.commit) begin
      valid_r[slot] <= 1'b1;
      fault_r       <= fault_nxt;
      for (int i = 0; i < FRAMES; i++) begin
        if (i < int'(n_used)) begin
          if (IDX_W'(i) == slot) begin
            age_r[i] <= AGE_BITS'(1);
          end else if (valid_r[i] && (age_r[i] != AGE_MAX)) begin
            age_r[i] <= age_r[i] + AGE_BITS'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && !hit_r) begin
      page_mem[slot] <= req_page_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data_r <= {3'b000, fault_nxt, evict_page, evicted,
                     slot_ext[lpr_pkg::IDX_OUT_W-1:0], hit_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  property p_commit_shows_result;
    @(posedge clk) disable iff (!rst_n) cmd.commit |=> out_valid_r;
  endproperty
  a_commit_shows_result: assert property (p_commit_shows_result)
    else $error("Committed item did not reach the output register.");

  property p_hit_no_evict;
    @(posedge clk) disable iff (!rst_n) out_valid_r |-> !(out_data_r[0] && out_data_r[4]);
  endproperty
  a_hit_no_evict: assert property (p_hit_no_evict)
    else $error("Result reports both a hit and an eviction.");

  property p_slot_valid;
    @(posedge clk) disable iff (!rst_n) cmd.commit |=> valid_r[$past(slot)];
  endproperty
  a_slot_valid: assert property (p_slot_valid)
    else $error("Chosen frame is not valid after commit.");

  property p_fault_monotonic;
    @(posedge clk) disable iff (!rst_n) cmd.commit |=> fault_r >= $past(fault_r);
  endproperty
  a_fault_monotonic: assert property (p_fault_monotonic)
    else $error("Fault count decreased on commit.");

endmodule

// ----- src/lru_page_replacement.sv -----
// Channel | Direction | Ports                      | Contents
// in      | sink      | in_tvalid/tready/tdata/tuser | tdata: page_number; tuser: start_of_string
// out     | source    | out_tvalid/tready/tdata     | tdata: hit, frame_index, evicted_valid,
//         |           |                            |        evicted_page, fault_total
// cfg     | sink      | cfg_wr_en/cfg_wr_data      | active_frames
//
// An item is accepted, then a sequential match and victim scan visits each active
// frame in turn, and then the frames are updated.
// Reset is synchronous and active low; all frames become empty and active_frames is 3.
// A result waits in the output register while the next item is accepted and scanned;
// the update of that next item holds until the output register is free.
module lru_page_replacement #(
  parameter int FRAMES    = 8,
  parameter int PAGE_BITS = 16,
  parameter int AGE_BITS  = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [lpr_pkg::CFG_W-1:0]       cfg_wr_data,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // page_number[15:0]
  input  logic [lpr_pkg::TDATA_IN_W-1:0]  in_tdata,
  // start_of_string
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // hit[0], frame_index[3:1], evicted_valid[4], evicted_page[20:5],
  // fault_total[36:21], zero[39:37]
  output logic [lpr_pkg::TDATA_OUT_W-1:0] out_tdata
);

  lpr_pkg::lpr_cmd_t cmd;
  lpr_pkg::lpr_sts_t sts;

  lpr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lpr_dp #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS),
    .AGE_BITS  (AGE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_tdata   (out_tdata),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule
